@@ sv/utf8_text_validator_assert.svh @@
// Assertion macros for the UTF-8 text validator.
// Clocked on clk; the reset-qualified form is disabled while rst is high.
`ifndef UTF8_TEXT_VALIDATOR_ASSERT_SVH
`define UTF8_TEXT_VALIDATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define UTF8V_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UTF8V_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTF8V_ASSERT(label, prop, msg)
`define UTF8V_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ sv/utf8v_pkg.sv @@
// Shared types, byte constants and decode functions of the UTF-8 text validator.
// No dependencies.
package utf8v_pkg;

  localparam logic [2:0] CLS_PLAIN = 3'd0;
  localparam logic [2:0] CLS_A0_BF = 3'd1;
  localparam logic [2:0] CLS_80_9F = 3'd2;
  localparam logic [2:0] CLS_90_BF = 3'd3;
  localparam logic [2:0] CLS_80_8F = 3'd4;

  localparam logic [7:0] B_80 = 8'h80;
  localparam logic [7:0] B_8F = 8'h8F;
  localparam logic [7:0] B_90 = 8'h90;
  localparam logic [7:0] B_9F = 8'h9F;
  localparam logic [7:0] B_A0 = 8'hA0;
  localparam logic [7:0] B_A5 = 8'hA5;
  localparam logic [7:0] B_BF = 8'hBF;
  localparam logic [7:0] B_C2 = 8'hC2;
  localparam logic [7:0] B_D4 = 8'hD4;
  localparam logic [7:0] B_DF = 8'hDF;
  localparam logic [7:0] B_E0 = 8'hE0;
  localparam logic [7:0] B_ED = 8'hED;
  localparam logic [7:0] B_EF = 8'hEF;
  localparam logic [7:0] B_F0 = 8'hF0;
  localparam logic [7:0] B_F4 = 8'hF4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } item_t;

  typedef struct packed {
    logic [1:0] bytes_left;
    logic [2:0] range_class;
    logic       lead_is_d4;
    logic       seen_error;
    logic       seen_non_ascii;
  } scan_state_t;

  function automatic logic in_class(input logic [7:0] b, input logic [2:0] cls);
    logic ok;
    case (cls)
      CLS_A0_BF: ok = (b >= B_A0) && (b <= B_BF);
      CLS_80_9F: ok = (b >= B_80) && (b <= B_9F);
      CLS_90_BF: ok = (b >= B_90) && (b <= B_BF);
      CLS_80_8F: ok = (b >= B_80) && (b <= B_8F);
      default:   ok = (b >= B_80) && (b <= B_BF);
    endcase
    return ok;
  endfunction

  function automatic scan_state_t scan_step(input scan_state_t s, input logic [7:0] b);
    scan_state_t n;
    n = s;
    n.seen_non_ascii = s.seen_non_ascii | b[7];
    if (!s.seen_error) begin
      if (s.bytes_left == 2'd0) begin
        n.range_class = CLS_PLAIN;
        n.lead_is_d4  = 1'b0;
        if (!b[7]) begin
          n.bytes_left = 2'd0;
        end else if ((b >= B_C2) && (b <= B_DF)) begin
          n.bytes_left = 2'd1;
          n.lead_is_d4 = (b == B_D4);
        end else if ((b >= B_E0) && (b <= B_EF)) begin
          n.bytes_left = 2'd2;
          if (b == B_E0) n.range_class = CLS_A0_BF;
          else if (b == B_ED) n.range_class = CLS_80_9F;
        end else if ((b >= B_F0) && (b <= B_F4)) begin
          n.bytes_left = 2'd3;
          if (b == B_F0) n.range_class = CLS_90_BF;
          else if (b == B_F4) n.range_class = CLS_80_8F;
        end else begin
          n.seen_error = 1'b1;
        end
      end else begin
        if (!in_class(b, s.range_class) ||
            ((s.bytes_left == 2'd1) && s.lead_is_d4 && (b == B_A5))) begin
          n.seen_error  = 1'b1;
          n.bytes_left  = 2'd0;
          n.range_class = CLS_PLAIN;
          n.lead_is_d4  = 1'b0;
        end else begin
          n.bytes_left  = s.bytes_left - 2'd1;
          n.range_class = CLS_PLAIN;
          if (s.bytes_left == 2'd1) n.lead_is_d4 = 1'b0;
        end
      end
    end
    return n;
  endfunction

endpackage

@@ sv/utf8v_ifs.sv @@
// Handshake channels of the UTF-8 text validator: text bytes in, verdict out.
// Depends on nothing.
interface utf8v_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;
  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink (input valid, input text_byte, input text_last, output ready);
endinterface

interface utf8v_verdict_if;
  logic valid;
  logic ready;
  logic is_utf8;
  modport source (output valid, output is_utf8, input ready);
  modport sink (input valid, input is_utf8, output ready);
endinterface

@@ sv/utf8v_in_stage.sv @@
// Input register of the UTF-8 text validator: holds one text item.
// Depends on utf8v_pkg and utf8v_text_if.
module utf8v_in_stage (
  input  logic               clk,
  input  logic               rst,
  utf8v_text_if.sink         text,
  output logic               item_valid,
  output utf8v_pkg::item_t   item,
  input  logic               take
);
  import utf8v_pkg::*;

  assign text.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text.ready) begin
      item_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item.text_byte <= text.text_byte;
      item.text_last <= text.text_last;
    end
  end

endmodule

@@ sv/utf8v_scan.sv @@
// Scan state, per-byte check and verdict register of the UTF-8 text validator.
// Depends on utf8v_pkg, utf8v_verdict_if and utf8_text_validator_assert.svh.
`include "utf8_text_validator_assert.svh"
module utf8v_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  utf8v_pkg::item_t   item,
  output logic               take,
  utf8v_verdict_if.source    verdict
);
  import utf8v_pkg::*;

  scan_state_t state;
  scan_state_t state_next;
  logic        out_valid;
  logic        out_bit;
  logic        verdict_next;

  assign state_next   = scan_step(state, item.text_byte);
  assign verdict_next = !state_next.seen_error && (state_next.bytes_left == 2'd0) &&
                        state_next.seen_non_ascii;
  assign take = item_valid && (!item.text_last || !out_valid || verdict.ready);

  assign verdict.valid   = out_valid;
  assign verdict.is_utf8 = out_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      // text end: back to reset state for the next text
      state <= item.text_last ? '0 : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && item.text_last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.text_last) begin
      out_bit <= verdict_next;
    end
  end

  `UTF8V_ASSERT(a_err_drops_seq, state.seen_error |-> (state.bytes_left == 2'd0), "open sequence kept after error")
  `UTF8V_ASSERT(a_narrow_needs_seq, (state.range_class != CLS_PLAIN) |-> (state.bytes_left >= 2'd2), "narrowed range without pending lead")
  `UTF8V_ASSERT(a_d4_two_byte, state.lead_is_d4 |-> (state.bytes_left == 2'd1), "D4 mark outside two-byte sequence")
  `UTF8V_ASSERT(a_end_clears, (take && item.text_last) |=> ((state == '0) && out_valid), "text end did not clear state")
  `UTF8V_ASSERT_ALWAYS(a_rst_idle, rst |=> (!out_valid && (state == '0)), "reset left state behind")

endmodule

@@ sv/utf8_text_validator.sv @@
// UTF-8 text validator: one byte item per cycle, one verdict item per text.
// The last byte of a text passes the input register, then the verdict register;
// throughput is 1 byte per cycle, set by the scan state update. A last byte waits
// in the input register while an earlier verdict is held and not taken.
// Reset: synchronous rst clears the scan state and both valid flags; a text is restarted.
module utf8_text_validator (
  input  logic            clk,
  input  logic            rst,
  utf8v_text_if.sink      text,
  utf8v_verdict_if.source verdict
);
  import utf8v_pkg::*;

  logic  item_valid;
  item_t item;
  logic  take;

  utf8v_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  utf8v_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .verdict    (verdict)
  );

endmodule

@@ tb/sv/utf8_text_validator_test.sv @@
`timescale 1ns / 100ps
// Self-checking test of utf8_text_validator: byte items in, one verdict item per text.
// Depends on utf8v_pkg, utf8v_ifs.sv and the validator RTL.
module utf8_text_validator_test;
  import utf8v_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 1200;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;
  typedef enum {TXT_CLEAN, TXT_SPLAT, TXT_CUT, TXT_D4A5, TXT_NARROW, TXT_NOISE,
                TXT_ASCII} text_kind_e;

  class verdict_tracker;
    logic       expected_verdicts[$];
    int         mismatches = 0;
    logic [1:0] cont_left = 2'd0;
    logic [2:0] cont_range = CLS_PLAIN;
    logic       lead_d4 = 1'b0;
    logic       err_seen = 1'b0;
    logic       high_seen = 1'b0;

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void clear_seq();
      cont_left = 2'd0;
      cont_range = CLS_PLAIN;
      lead_d4 = 1'b0;
    endfunction

    function logic cont_fits(input logic [7:0] b);
      case (cont_range)
        CLS_A0_BF: return b >= B_A0 && b <= B_BF;
        CLS_80_9F: return b >= B_80 && b <= B_9F;
        CLS_90_BF: return b >= B_90 && b <= B_BF;
        CLS_80_8F: return b >= B_80 && b <= B_8F;
        default:   return b >= B_80 && b <= B_BF;
      endcase
    endfunction

    function void take_byte(input logic [7:0] b, input logic last);
      if (b[7]) high_seen = 1'b1;
      if (!err_seen) begin
        if (cont_left == 2'd0) begin
          clear_seq();
          if (!b[7]) begin
          end else if (b >= B_C2 && b <= B_DF) begin
            cont_left = 2'd1;
            lead_d4 = (b == B_D4);
          end else if (b >= B_E0 && b <= B_EF) begin
            cont_left = 2'd2;
            if (b == B_E0) cont_range = CLS_A0_BF;
            else if (b == B_ED) cont_range = CLS_80_9F;
          end else if (b >= B_F0 && b <= B_F4) begin
            cont_left = 2'd3;
            if (b == B_F0) cont_range = CLS_90_BF;
            else if (b == B_F4) cont_range = CLS_80_8F;
          end else begin
            err_seen = 1'b1;
          end
        end else if (!cont_fits(b) || (cont_left == 2'd1 && lead_d4 && b == B_A5)) begin
          err_seen = 1'b1;
          clear_seq();
        end else begin
          cont_left = cont_left - 2'd1;
          cont_range = CLS_PLAIN;
          if (cont_left == 2'd0) lead_d4 = 1'b0;
        end
      end
      if (last) begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 !err_seen && cont_left == 2'd0 && high_seen);
        clear_seq();
        err_seen = 1'b0;
        high_seen = 1'b0;
      end
    endfunction

    task check_verdict(input logic got);
      logic want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0b with no text pending", got));
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) report_mismatch($sformatf("is_utf8 %0b, expected %0b", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  utf8v_text_if    text_ch ();
  utf8v_verdict_if verdict_ch ();

  verdict_tracker tracker = new;
  logic [7:0] text_buf[$];
  int         burst_left = 0;
  int         byte_count = 0;
  int         cycle_count = 0;
  rx_mode_e   rx_mode = RX_ALWAYS;
  int         rx_left = 0;
  int         rx_phase = 0;

  utf8_text_validator i_dut (
    .clk(clk),
    .rst(rst),
    .text(text_ch),
    .verdict(verdict_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) tracker.take_byte(text_ch.text_byte, text_ch.text_last);
      if (verdict_ch.valid && verdict_ch.ready) tracker.check_verdict(verdict_ch.is_utf8);
    end
  end

  // verdict receiver: picks a new stall pattern each time its run counter runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_ALWAYS:   verdict_ch.ready <= 1'b1;
      RX_RANDOM:   verdict_ch.ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: verdict_ch.ready <= (rx_phase % 5) >= 2;
      default:     verdict_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void put_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        text_ch.text_byte <= 8'($urandom_range(0, 255));
        text_ch.text_last <= 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.text_last <= last;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
      byte_count++;
    end
  endtask

  task automatic add_char();
    int unsigned cp;
    int unsigned edge_cps[10];
    logic [20:0] c;
    edge_cps = '{'h0, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF, 'h10000, 'h10FFFF};
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(0, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: begin
        cp = $urandom_range('h800, 'hFFFF);
        if (cp >= 'hD800 && cp <= 'hDFFF) cp -= 'h800;
      end
      default: cp = $urandom_range('h10000, 'h10FFFF);
    endcase
    if ($urandom_range(0, 4) == 0) cp = edge_cps[$urandom_range(0, 9)];
    c = cp[20:0];
    if (cp < 'h80) begin
      put_byte(c[7:0]);
    end else if (cp < 'h800) begin
      put_byte(8'hC0 | c[10:6]);
      put_byte(B_80 | c[5:0]);
    end else if (cp < 'h10000) begin
      put_byte(B_E0 | c[15:12]);
      put_byte(B_80 | c[11:6]);
      put_byte(B_80 | c[5:0]);
    end else begin
      put_byte(B_F0 | c[20:18]);
      put_byte(B_80 | c[17:12]);
      put_byte(B_80 | c[11:6]);
      put_byte(B_80 | c[5:0]);
    end
  endtask

  task automatic build_text();
    int r;
    int n;
    text_kind_e kind;
    logic [7:0] lead;
    r = $urandom_range(0, 99);
    if (r < 55) kind = TXT_CLEAN;
    else if (r < 63) kind = TXT_SPLAT;
    else if (r < 71) kind = TXT_CUT;
    else if (r < 78) kind = TXT_D4A5;
    else if (r < 86) kind = TXT_NARROW;
    else if (r < 93) kind = TXT_NOISE;
    else kind = TXT_ASCII;
    text_buf.delete();
    case (kind)
      TXT_ASCII: begin
        n = $urandom_range(1, 8);
        repeat (n) put_byte(8'($urandom_range(0, 'h7F)));
      end
      TXT_NOISE: begin
        n = $urandom_range(1, 8);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
      TXT_D4A5: begin
        if ($urandom_range(0, 1)) add_char();
        put_byte(B_D4);
        put_byte(B_A5);
        if ($urandom_range(0, 1)) add_char();
      end
      TXT_NARROW: begin
        if ($urandom_range(0, 1)) add_char();
        case ($urandom_range(0, 3))
          0: lead = B_E0;
          1: lead = B_ED;
          2: lead = B_F0;
          default: lead = B_F4;
        endcase
        put_byte(lead);
        put_byte(8'($urandom_range(B_80, B_BF)));
        repeat ((lead >= B_F0) ? 2 : 1) put_byte(8'($urandom_range(B_80, B_BF)));
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) add_char();
        if (kind == TXT_SPLAT) text_buf[$urandom_range(0, text_buf.size() - 1)] =
            8'($urandom_range(0, 255));
        if (kind == TXT_CUT && text_buf.size() > 1) void'(text_buf.pop_back());
      end
    endcase
  endtask

  initial begin
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = 8'h00;
    text_ch.text_last = 1'b0;
    verdict_ch.ready = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    text_buf = '{8'h00, 8'h7F, B_C2, B_80};
    send_text();
    text_buf = '{B_D4, B_A5};
    send_text();
    text_buf = '{B_E0, B_9F, B_80};      // overlong: below narrowed range
    send_text();
    text_buf = '{B_F4, B_8F, B_BF, B_BF};
    send_text();
    text_buf = '{8'hFF, 8'h41};          // bad lead, then bytes after the error
    send_text();
    text_buf = '{8'h41};                 // all ASCII
    send_text();
    text_buf = '{B_ED, B_9F, B_BF};
    send_text();
    text_buf = '{B_F0, B_90, B_80};      // unfinished sequence
    send_text();
    text_buf = '{B_C2, 8'h41};           // continuation not 10xxxxxx
    send_text();

    byte_count = 0;
    while (byte_count < RANDOM_BYTES) begin
      build_text();
      send_text();
    end
    text_ch.valid <= 1'b0;

    while (tracker.expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
